/* design/icsp_command_bridge_macros.svh */
// Assertion macros shared by the checker of the command bridge.
`ifndef ICSP_COMMAND_BRIDGE_MACROS_SVH
`define ICSP_COMMAND_BRIDGE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ICSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("icsp command bridge assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ICSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("icsp command bridge assertion failed");

`endif

/* design/icsp_pkg.sv */
`default_nettype none
package icsp_pkg;

  // Default number of jobs held between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;
  localparam logic [1:0] KIND_PIN   = 2'd3;

  // Host command letters.
  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_L = 8'h4C;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_I = 8'h49;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_Q = 8'h51;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_X = 8'h58;
  localparam logic [7:0] CHAR_Y = 8'h59;

  // Link opcodes, six bits each.
  localparam logic [5:0] OP_LOAD_CONFIG = 6'h00;
  localparam logic [5:0] OP_LOAD_DATA   = 6'h02;
  localparam logic [5:0] OP_READ_DATA   = 6'h04;
  localparam logic [5:0] OP_INC_ADDR    = 6'h06;
  localparam logic [5:0] OP_INC_ALT     = 6'h16;
  localparam logic [5:0] OP_PROG_INT    = 6'h08;
  localparam logic [5:0] OP_PROG_EXT    = 6'h18;
  localparam logic [5:0] OP_END_PROG    = 6'h0A;
  localparam logic [5:0] OP_BULK_ERASE  = 6'h09;
  localparam logic [5:0] OP_ROW_ERASE   = 6'h11;

  localparam logic [31:0] ENTRY_KEY = 32'h4D434850;
  localparam logic [7:0]  MARK      = 8'h80;

  // One unit of work for the back: an optional pin change, a run of driven
  // bits sent LSB first, an optional read clock and up to two reply bytes.
  typedef struct packed {
    logic        pin_pend;
    logic        pin_val;
    logic [5:0]  nbits;
    logic [32:0] bits;
    logic        read_pend;
    logic [1:0]  nbytes;
    logic [15:0] bytes;
  } job_t;

endpackage
`default_nettype wire

/* design/icsp_front.sv */
`default_nettype none
module icsp_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [7:0]  host_byte,
  input  wire logic        sample_bit,
  input  wire logic        full,
  output logic             push,
  output icsp_pkg::job_t   push_job
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_READ   = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic        load_is_data, load_is_data_next;
  logic [6:0]  value_high, value_high_next;
  logic [15:0] read_shift, read_shift_next;
  logic [4:0]  read_count, read_count_next;

  logic        accept;
  logic        has_job;
  logic [13:0] load_value;
  logic [13:0] sampled_word;
  logic [15:0] shift_sum;
  logic [4:0]  count_sum;

  assign in_stall = full;
  assign accept   = in_valid & ~full;
  assign push     = accept & has_job;

  assign load_value   = {value_high, host_byte[6:0]};
  assign shift_sum    = read_shift | (16'(sample_bit) << read_count[3:0]);
  assign count_sum    = read_count + 5'd1;
  assign sampled_word = shift_sum[14:1];

  always_comb begin
    phase_next        = phase;
    load_is_data_next = load_is_data;
    value_high_next   = value_high;
    read_shift_next   = read_shift;
    read_count_next   = read_count;
    has_job           = 1'b0;
    push_job          = '0;
    if (!operation) begin
      case (phase)
        PH_FIRST: begin
          if (host_byte[7]) begin
            value_high_next = host_byte[6:0];
            phase_next      = PH_SECOND;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_SECOND: begin
          phase_next = PH_IDLE;
          if (host_byte[7]) begin
            has_job             = 1'b1;
            push_job.nbits      = 6'd22;
            push_job.bits[5:0]  = load_is_data ? icsp_pkg::OP_LOAD_DATA
                                               : icsp_pkg::OP_LOAD_CONFIG;
            push_job.bits[21:6] = {1'b0, load_value, 1'b0};
          end
        end
        PH_READ: begin
          // Host bytes are dropped while a read is in progress.
        end
        default: begin
          case (host_byte)
            icsp_pkg::CHAR_B: begin
              has_job           = 1'b1;
              push_job.pin_pend = 1'b1;
              push_job.pin_val  = 1'b1;
              push_job.nbits    = 6'd33;
              push_job.bits     = {1'b0, icsp_pkg::ENTRY_KEY};
            end
            icsp_pkg::CHAR_E: begin
              has_job           = 1'b1;
              push_job.pin_pend = 1'b1;
            end
            icsp_pkg::CHAR_T: begin
              has_job         = 1'b1;
              push_job.nbytes = 2'd1;
              push_job.bytes  = {icsp_pkg::CHAR_Y, 8'h00};
            end
            icsp_pkg::CHAR_C, icsp_pkg::CHAR_L: begin
              load_is_data_next = (host_byte == icsp_pkg::CHAR_L);
              phase_next        = PH_FIRST;
            end
            icsp_pkg::CHAR_R: begin
              has_job            = 1'b1;
              push_job.nbits     = 6'd6;
              push_job.bits[5:0] = icsp_pkg::OP_READ_DATA;
              push_job.read_pend = 1'b1;
              read_shift_next    = '0;
              read_count_next    = '0;
              phase_next         = PH_READ;
            end
            icsp_pkg::CHAR_I: begin
              has_job            = 1'b1;
              push_job.nbits     = 6'd6;
              push_job.bits[5:0] = icsp_pkg::OP_INC_ADDR;
            end
            icsp_pkg::CHAR_A: begin
              has_job            = 1'b1;
              push_job.nbits     = 6'd6;
              push_job.bits[5:0] = icsp_pkg::OP_INC_ALT;
            end
            icsp_pkg::CHAR_P: begin
              has_job            = 1'b1;
              push_job.nbits     = 6'd6;
              push_job.bits[5:0] = icsp_pkg::OP_PROG_INT;
            end
            icsp_pkg::CHAR_Q: begin
              has_job            = 1'b1;
              push_job.nbits     = 6'd6;
              push_job.bits[5:0] = icsp_pkg::OP_PROG_EXT;
            end
            icsp_pkg::CHAR_S: begin
              has_job            = 1'b1;
              push_job.nbits     = 6'd6;
              push_job.bits[5:0] = icsp_pkg::OP_END_PROG;
            end
            icsp_pkg::CHAR_X: begin
              has_job            = 1'b1;
              push_job.nbits     = 6'd6;
              push_job.bits[5:0] = icsp_pkg::OP_BULK_ERASE;
            end
            icsp_pkg::CHAR_Y: begin
              has_job            = 1'b1;
              push_job.nbits     = 6'd6;
              push_job.bits[5:0] = icsp_pkg::OP_ROW_ERASE;
            end
            default: begin
              // Unknown command letters produce nothing.
            end
          endcase
        end
      endcase
    end else if (phase == PH_READ) begin
      has_job = 1'b1;
      if (!count_sum[4]) begin
        read_shift_next    = shift_sum;
        read_count_next    = count_sum;
        push_job.read_pend = 1'b1;
      end else begin
        read_shift_next = shift_sum;
        read_count_next = '0;
        phase_next      = PH_IDLE;
        push_job.nbytes = 2'd2;
        push_job.bytes  = {icsp_pkg::MARK | {1'b0, sampled_word[13:7]},
                           icsp_pkg::MARK | {1'b0, sampled_word[6:0]}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      load_is_data <= 1'b0;
      value_high   <= '0;
      read_shift   <= '0;
      read_count   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      load_is_data <= load_is_data_next;
      value_high   <= value_high_next;
      read_shift   <= read_shift_next;
      read_count   <= read_count_next;
    end
  end

endmodule
`default_nettype wire

/* design/icsp_queue.sv */
`default_nettype none
module icsp_queue #(
  parameter int DEPTH = icsp_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  icsp_pkg::job_t      push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output icsp_pkg::job_t      q_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  icsp_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_job   = slots[rptr];
  assign do_pop  = pop & q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* design/icsp_back.sv */
`default_nettype none
module icsp_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  icsp_pkg::job_t   q_job,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic             data_bit,
  output logic [7:0]       reply_byte,
  output logic             drive_pins,
  output logic             last
);

  icsp_pkg::job_t cur, cur_next;
  logic           active;
  logic           adv;
  logic           load;
  logic [1:0]     r_kind;
  logic           r_bit;
  logic [7:0]     r_byte;
  logic           r_drive;
  logic           r_last;

  // Result of the job in hand, in the order pin change, bits, read, bytes.
  always_comb begin
    cur_next = cur;
    r_kind   = icsp_pkg::KIND_REPLY;
    r_bit    = 1'b0;
    r_byte   = 8'h00;
    r_drive  = 1'b0;
    if (cur.pin_pend) begin
      r_kind           = icsp_pkg::KIND_PIN;
      r_drive          = cur.pin_val;
      cur_next.pin_pend = 1'b0;
    end else if (cur.nbits != '0) begin
      r_kind         = icsp_pkg::KIND_DATA;
      r_bit          = cur.bits[0];
      cur_next.bits  = cur.bits >> 1;
      cur_next.nbits = cur.nbits - 6'd1;
    end else if (cur.read_pend) begin
      r_kind             = icsp_pkg::KIND_READ;
      cur_next.read_pend = 1'b0;
    end else begin
      r_byte          = cur.bytes[15:8];
      cur_next.bytes  = cur.bytes << 8;
      cur_next.nbytes = cur.nbytes - 2'd1;
    end
    r_last = !cur_next.pin_pend && (cur_next.nbits == '0) && !cur_next.read_pend
             && (cur_next.nbytes == '0);
  end

  assign adv  = ~out_valid | ~out_stall;
  assign load = adv & (~active | r_last) & q_valid;
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= active;
      if (!active || r_last) begin
        active <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (active) begin
        kind       <= r_kind;
        data_bit   <= r_bit;
        reply_byte <= r_byte;
        drive_pins <= r_drive;
        last       <= r_last;
      end
      if (load) begin
        cur <= q_job;
      end else if (active) begin
        cur <= cur_next;
      end
    end
  end

endmodule
`default_nettype wire

/* design/icsp_command_bridge.sv */
// Path: an accepted item's job passes the queue, the back's job register and the output
// register. Throughput: the back gives one result per cycle unless stalled; a job has
// 1 to 34 results, and the front takes one item per cycle while the job queue has room.
// Reset: rst is synchronous and active high; it returns the command phase to idle, clears
// the read counters and empties the queue and the output register.
`default_nettype none
module icsp_command_bridge #(
  parameter int QUEUE_DEPTH = icsp_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       operation,
  input  wire logic [7:0] host_byte,
  input  wire logic       sample_bit,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic            data_bit,
  output logic [7:0]      reply_byte,
  output logic            drive_pins,
  output logic            last
);

  // The front decodes host bytes and sample bits as they arrive and turns each
  // into at most one job. Its state (load phase, value byte, read shift and
  // count) moves on at the moment the item is accepted, so it never waits on
  // the pin side. It stalls only when the queue is full.
  logic           push;
  logic           full;
  icsp_pkg::job_t push_job;

  // The queue decouples the two sides: a 34-result entry sequence can drain
  // through the back while the host keeps sending further commands.
  logic           q_valid;
  logic           pop;
  icsp_pkg::job_t q_job;

  icsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .host_byte  (host_byte),
    .sample_bit (sample_bit),
    .full       (full),
    .push       (push),
    .push_job   (push_job)
  );

  icsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // The back walks each job one result per cycle, unless stalled, into a registered output.
  // It picks up the next job in the same cycle that the last result of the
  // current one is loaded, so consecutive jobs leave without a gap.
  icsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .data_bit   (data_bit),
    .reply_byte (reply_byte),
    .drive_pins (drive_pins),
    .last       (last)
  );

endmodule
`default_nettype wire

/* design/icsp_command_bridge_checker.sv */
`default_nettype none
`include "icsp_command_bridge_macros.svh"
module icsp_command_bridge_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] kind,
  input wire logic       data_bit,
  input wire logic [7:0] reply_byte,
  input wire logic       drive_pins,
  input wire logic       last
);

  // A stalled result stays offered.
  `ICSP_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid)

  // A read clock always ends the work of its item.
  `ICSP_ASSERT_NOW(a_read_is_last, out_valid && kind == icsp_pkg::KIND_READ, last)

  // Fields that do not belong to the shown kind read as zero.
  `ICSP_ASSERT_NOW(a_bit_only_data, out_valid && kind != icsp_pkg::KIND_DATA, !data_bit)
  `ICSP_ASSERT_NOW(a_byte_only_reply, out_valid && kind != icsp_pkg::KIND_REPLY,
                   reply_byte == 8'h00)
  `ICSP_ASSERT_NOW(a_drive_only_pin, out_valid && kind != icsp_pkg::KIND_PIN, !drive_pins)

endmodule

bind icsp_command_bridge icsp_command_bridge_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .data_bit   (data_bit),
  .reply_byte (reply_byte),
  .drive_pins (drive_pins),
  .last       (last)
);
`default_nettype wire
